FILE: rtl/transposition_table_probe_record_core_defines.svh
// ----------------------------------------------------------------------------
// Transposition table core: assertion macros
// Shared concurrent assertion forms for the table core.
// ----------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_PROBE_RECORD_CORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_RECORD_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TTPR_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TTPR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ttpr_pkg.sv
// ----------------------------------------------------------------------------
// Transposition table core: package
// Types, codes and constants shared by the table core and its interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttpr_pkg;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_PROBE  = 2'd0,
    OP_RECORD = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // bound kinds stored with an entry
  typedef enum logic [1:0] {
    KIND_UPPER = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_EXACT = 2'd2
  } kind_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_READ,
    ST_EXEC,
    ST_CLEAR
  } state_e;

  // configuration register file
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAN = 1'b1;
  localparam logic [CFG_W-1:0] WIN_RESET = 14'd9800;
  localparam logic [CFG_W-1:0] BAN_RESET = 14'd9900;

  // field widths
  localparam int unsigned SCORE_W = 15;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned LOCK_W  = 32;
  localparam int unsigned KEY_W   = 32;

  // 16-bit working range of scores
  localparam logic signed [15:0] SCORE_MAX = 16'sd16383;
  localparam logic signed [15:0] SCORE_MIN = -16'sd16384;

  // one table entry
  typedef struct packed {
    logic        [DEPTH_W-1:0] depth;
    logic        [1:0]         kind;
    logic signed [SCORE_W-1:0] score;
    logic        [MOVE_W-1:0]  move;
    logic        [LOCK_W-1:0]  lock;
  } entry_t;

endpackage

FILE: rtl/ttpr_in_if.sv
// ----------------------------------------------------------------------------
// Transposition table core: request channel
// Valid/ready channel carrying one probe, record or clear request per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ttpr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [1:0]                      operation;
  logic        [ttpr_pkg::KEY_W-1:0]      position_key;
  logic        [ttpr_pkg::LOCK_W-1:0]     position_lock;
  logic        [ttpr_pkg::DEPTH_W-1:0]    search_depth;
  logic        [ttpr_pkg::DEPTH_W-1:0]    ply_distance;
  logic signed [ttpr_pkg::SCORE_W-1:0]    alpha_bound;
  logic signed [ttpr_pkg::SCORE_W-1:0]    beta_bound;
  logic signed [ttpr_pkg::SCORE_W-1:0]    draw_score;
  logic        [1:0]                      bound_kind;
  logic signed [ttpr_pkg::SCORE_W-1:0]    score;
  logic        [ttpr_pkg::MOVE_W-1:0]     best_move;

  modport source (
    output valid, operation, position_key, position_lock, search_depth,
    output ply_distance, alpha_bound, beta_bound, draw_score, bound_kind,
    output score, best_move,
    input  ready
  );

  modport sink (
    input  valid, operation, position_key, position_lock, search_depth,
    input  ply_distance, alpha_bound, beta_bound, draw_score, bound_kind,
    input  score, best_move,
    output ready
  );
endinterface

FILE: rtl/ttpr_out_if.sv
// ----------------------------------------------------------------------------
// Transposition table core: result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ttpr_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [ttpr_pkg::SCORE_W-1:0] hit_score;
  logic        [ttpr_pkg::MOVE_W-1:0]  hash_move;
  logic                                stored;

  modport source (
    output valid, hit, hit_score, hash_move, stored,
    input  ready
  );

  modport sink (
    input  valid, hit, hit_score, hash_move, stored,
    output ready
  );
endinterface

FILE: rtl/transposition_table_probe_record_core.sv
// ----------------------------------------------------------------------------
// Transposition table core
// Depth-preferred game-search hash table: probe, record and clear over one
// synchronous entry memory, with mate-distance score correction.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Beat contents
//  in_i      in   valid / ready      operation, key, lock, depth, ply, window,
//                                    draw score, bound kind, score, move
//  out_o     out  valid / ready      hit, hit_score, hash_move, stored
//  cfg       in   cfg_we_i           register index, 14-bit write data
//
//  Probe, record and the unused code run from accept to the next accept through
//  accept (slot multiply), slot remainder, memory read and update.
//  Clear then adds a sweep over all TABLE_ENTRIES entries, one entry a cycle.
//  After reset a clearing pass over all entries runs with in_i.ready low.
//  The result register lets a new request in while a result waits; the update
//  step holds (no memory write) while the result register is full and out_o.ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module transposition_table_probe_record_core #(
  parameter int unsigned TABLE_ENTRIES = 32767
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ttpr_in_if.sink                            in_i,
  ttpr_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [ttpr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ttpr_pkg::CFG_W-1:0]         cfg_wdata_i
);

`include "transposition_table_probe_record_core_defines.svh"

  localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned REM_W  = ADDR_W + 1;
  // floor(2^31 / N): quotient estimate is at most one short
  localparam logic [31:0] RECIP = 32'(64'h8000_0000 / 64'(TABLE_ENTRIES));
  localparam logic [REM_W-1:0]  TBL_NW   = REM_W'(TABLE_ENTRIES);
  localparam logic [ADDR_W-1:0] TBL_LAST = ADDR_W'(TABLE_ENTRIES - 1);

  // --------------------------------------------------------------------------
  // declarations
  // --------------------------------------------------------------------------
  ttpr_pkg::state_e state_q, state_d;

  logic [ttpr_pkg::CFG_W-1:0] win_q, ban_q;

  // request held for the duration of one operation
  ttpr_pkg::op_e                        op_q;
  logic        [ttpr_pkg::LOCK_W-1:0]   lock_q;
  logic        [ttpr_pkg::DEPTH_W-1:0]  depth_q;
  logic        [ttpr_pkg::DEPTH_W-1:0]  ply_q;
  logic signed [ttpr_pkg::SCORE_W-1:0]  alpha_q, beta_q, draw_q, score_q;
  logic        [1:0]                    kind_q;
  logic        [ttpr_pkg::MOVE_W-1:0]   move_q;
  logic        [REM_W-1:0]              keylo_q;
  logic        [REM_W-1:0]              quot_q;
  logic        [REM_W-1:0]              rem_q;
  logic        [ADDR_W-1:0]             slot_q;

  logic [62:0]       prod;
  logic [REM_W-1:0]  rem_d;
  logic [REM_W-1:0]  rem_red;
  logic [ADDR_W-1:0] rd_addr;

  // entry memory
  ttpr_pkg::entry_t   tbl_mem [TABLE_ENTRIES];
  ttpr_pkg::entry_t   rd_data_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  ttpr_pkg::entry_t   mem_wdata;

  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  logic in_acc, exec_go, clr_last;

  // result register
  logic                                out_valid_q;
  logic                                hit_q, stored_q;
  logic signed [ttpr_pkg::SCORE_W-1:0] hit_score_q;
  logic        [ttpr_pkg::MOVE_W-1:0]  hash_move_q;

  // update step results
  logic                                res_hit, res_stored;
  logic signed [ttpr_pkg::SCORE_W-1:0] res_score;
  logic        [ttpr_pkg::MOVE_W-1:0]  res_move;
  logic                                rec_we;
  ttpr_pkg::entry_t                    rec_entry;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= ttpr_pkg::WIN_RESET;
      ban_q <= ttpr_pkg::BAN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttpr_pkg::CFG_WIN: win_q <= cfg_wdata_i;
        ttpr_pkg::CFG_BAN: ban_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // slot = key[30:0] mod N: reciprocal multiply, remainder, one correction
  // --------------------------------------------------------------------------
  assign in_acc = in_i.valid && in_i.ready;
  assign prod   = 63'(in_i.position_key[30:0]) * 63'(RECIP);
  // only the low bits matter: the true remainder stays below 2N
  assign rem_d   = keylo_q - REM_W'(quot_q * TBL_NW);
  assign rem_red = (rem_q >= TBL_NW) ? (rem_q - TBL_NW) : rem_q;
  assign rd_addr = rem_red[ADDR_W-1:0];

  // request capture and slot pipeline
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= ttpr_pkg::op_e'(in_i.operation);
      lock_q  <= in_i.position_lock;
      depth_q <= in_i.search_depth;
      ply_q   <= in_i.ply_distance;
      alpha_q <= in_i.alpha_bound;
      beta_q  <= in_i.beta_bound;
      draw_q  <= in_i.draw_score;
      kind_q  <= in_i.bound_kind;
      score_q <= in_i.score;
      move_q  <= in_i.best_move;
      keylo_q <= in_i.position_key[REM_W-1:0];
      quot_q  <= prod[31 +: REM_W];
    end
    if (state_q == ttpr_pkg::ST_SLOT) begin
      rem_q <= rem_d;
    end
    if (state_q == ttpr_pkg::ST_READ) begin
      slot_q <= rd_addr;
    end
  end

  // --------------------------------------------------------------------------
  // entry memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= tbl_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // update step: probe and record against the entry just read
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [15:0] v16, w16, b16, ply16, d16, vc16;
    logic signed [15:0] a16, bt16, s16, nv16;
    logic               match, pos_m, neg_m, miss, mate, depth_ok, kind_ok;
    logic               r_pos, r_neg, abort, no_move;

    w16   = {2'b00, win_q};
    b16   = {2'b00, ban_q};
    ply16 = {10'd0, ply_q};
    d16   = {draw_q[14], draw_q};
    a16   = {alpha_q[14], alpha_q};
    bt16  = {beta_q[14], beta_q};
    s16   = {score_q[14], score_q};
    v16   = {rd_data_q.score[14], rd_data_q.score};

    // probe: lock check, banned / draw misses, mate correction
    match = (rd_data_q.lock == lock_q);
    pos_m = (v16 > w16);
    neg_m = (v16 < -w16);
    miss  = 1'b0;
    mate  = 1'b0;
    vc16  = v16;
    if (pos_m) begin
      if (v16 <= b16) miss = 1'b1;
      else begin
        mate = 1'b1;
        vc16 = v16 - ply16;
      end
    end else if (neg_m) begin
      if (v16 >= -b16) miss = 1'b1;
      else begin
        mate = 1'b1;
        vc16 = v16 + ply16;
      end
    end else if (v16 == d16) begin
      miss = 1'b1;
    end
    depth_ok = (rd_data_q.depth >= depth_q);
    if (rd_data_q.kind == 2'(ttpr_pkg::KIND_LOWER)) kind_ok = (vc16 >= bt16);
    else if (rd_data_q.kind == 2'(ttpr_pkg::KIND_UPPER)) kind_ok = (vc16 <= a16);
    else kind_ok = 1'b1;

    // record: boundary scores without a move only refresh kind and depth
    no_move = (move_q == '0);
    r_pos   = (s16 > w16);
    r_neg   = (s16 < -w16);
    if (r_pos) begin
      abort = no_move && (s16 <= b16);
      nv16  = s16 + ply16;
    end else if (r_neg) begin
      abort = no_move && (s16 >= -b16);
      nv16  = s16 - ply16;
    end else begin
      abort = no_move && (s16 == d16);
      nv16  = s16;
    end
    if (nv16 > ttpr_pkg::SCORE_MAX) nv16 = ttpr_pkg::SCORE_MAX;
    else if (nv16 < ttpr_pkg::SCORE_MIN) nv16 = ttpr_pkg::SCORE_MIN;

    rec_entry       = rd_data_q;
    rec_entry.depth = depth_q;
    rec_entry.kind  = kind_q;
    if (!abort) begin
      rec_entry.score = nv16[14:0];
      rec_entry.move  = move_q;
      rec_entry.lock  = lock_q;
    end

    res_hit    = 1'b0;
    res_score  = '0;
    res_move   = '0;
    res_stored = 1'b0;
    rec_we     = 1'b0;
    unique case (op_q)
      ttpr_pkg::OP_PROBE: begin
        if (match) begin
          res_move = rd_data_q.move;
          res_hit  = !miss && (depth_ok ? kind_ok : mate);
          if (res_hit) res_score = vc16[14:0];
        end
      end
      ttpr_pkg::OP_RECORD: begin
        rec_we     = (rd_data_q.depth <= depth_q);
        res_stored = rec_we && !abort;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // controller: next state
  // --------------------------------------------------------------------------
  assign exec_go  = (state_q == ttpr_pkg::ST_EXEC) && (!out_valid_q || out_o.ready);
  assign clr_last = (clr_cnt_q == TBL_LAST);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttpr_pkg::ST_IDLE:  if (in_acc) state_d = ttpr_pkg::ST_SLOT;
      ttpr_pkg::ST_SLOT:  state_d = ttpr_pkg::ST_READ;
      ttpr_pkg::ST_READ:  state_d = ttpr_pkg::ST_EXEC;
      ttpr_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_d = (op_q == ttpr_pkg::OP_CLEAR) ? ttpr_pkg::ST_CLEAR : ttpr_pkg::ST_IDLE;
        end
      end
      ttpr_pkg::ST_CLEAR: if (clr_last) state_d = ttpr_pkg::ST_IDLE;
      default:            state_d = ttpr_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // controller: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = slot_q;
    mem_wdata  = rec_entry;
    clr_cnt_d  = clr_cnt_q;
    unique case (state_q)
      ttpr_pkg::ST_IDLE: in_i.ready = 1'b1;
      ttpr_pkg::ST_EXEC: mem_we = exec_go && rec_we;
      ttpr_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_last ? '0 : clr_cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // state, sweep counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttpr_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (exec_go) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      hit_q       <= res_hit;
      hit_score_q <= res_score;
      hash_move_q <= res_move;
      stored_q    <= res_stored;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hit       = hit_q;
  assign out_o.hit_score = hit_score_q;
  assign out_o.hash_move = hash_move_q;
  assign out_o.stored    = stored_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `TTPR_ASSERT_IMPL(a_slot_in_range, clk_i, rst_ni, state_q == ttpr_pkg::ST_READ, rem_red < TBL_NW, "slot remainder not reduced below table size")
  `TTPR_ASSERT_IMPL(a_result_from_update, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ttpr_pkg::ST_EXEC), "result appeared without an update step")
  `TTPR_ASSERT_NEXT(a_update_leaves, clk_i, rst_ni, exec_go, state_q == ttpr_pkg::ST_IDLE || state_q == ttpr_pkg::ST_CLEAR, "update step did not retire")

endmodule
